// ===== design/ptq_pkg.sv =====
// shared constants, codes and state type for the periodic timer queue
`timescale 1ns / 1ps

package ptq_pkg;

    localparam int NUM_TIMERS_DEF = 16;

    localparam int TIME_W    = 48;
    localparam int PERIOD_W  = 32;
    localparam int SLOT_W    = 4;
    localparam int ELAPSED_W = 16;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [2:0] KIND_ADDED    = 3'd0;
    localparam logic [2:0] KIND_FULL     = 3'd1;
    localparam logic [2:0] KIND_REMOVED  = 3'd2;
    localparam logic [2:0] KIND_NOTFOUND = 3'd3;
    localparam logic [2:0] KIND_EXPIRED  = 3'd4;
    localparam logic [2:0] KIND_TICKDONE = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_TICK_SCAN,
        ST_TICK_UPD,
        ST_EXP_OUT,
        ST_FIN_SCAN,
        ST_FIN_CALC,
        ST_FIN_OUT
    } ptq_state_t;

endpackage

// ===== design/periodic_timer_queue.sv =====
// periodic timer queue: slot table, time counter and scan sequencer
`timescale 1ns / 1ps

// Commands enter on the s_ channel: s_tuser carries the operation (add, remove,
// tick) and s_tdata the period, repeat flag, slot and elapsed time. Results
// leave on the m_ channel: m_tuser carries the result kind, m_tdata the slot,
// remaining time and empty flag, and m_tlast marks the final beat of a command.
// One command is worked at a time; s_tready is high only while the sequencer
// is idle. The deadline table sits in a one-read, one-write memory, and the
// deadline searches walk it one slot a cycle through a single compare stage.
// A remove makes one pass over the table, and an add first looks for a
// free slot and then makes one; a tick makes a further pass for each timer
// that expires, as each needs its own pass to find the next earliest deadline.
// A tick beat of elapsed time is added with the same 48-bit adder that forms
// new deadlines. The result register frees the sequencer as soon as the last
// beat is loaded; a stalled receiver holds the beat and stops the sequencer
// only when it has a further beat to load.
// Reset clears the time counter and disarms every slot; the memory is not
// cleared, as a slot's entry is read only once it is armed.
module periodic_timer_queue #(
    parameter int NUM_TIMERS = ptq_pkg::NUM_TIMERS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // period[31:0], repeat_req[32], slot[36:33], elapsed[52:37], zero fill
    input  logic [ptq_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation[1:0]
    input  logic [ptq_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // timer_slot[3:0], remaining[35:4], empty_res[36], zero fill
    output logic [ptq_pkg::M_TDATA_W-1:0]  m_tdata,
    // kind[2:0]
    output logic [ptq_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                           m_tlast
);

    import ptq_pkg::*;

    localparam int IdxW     = $clog2(NUM_TIMERS);
    localparam int SlotCmpW = (IdxW + 1 > SLOT_W) ? IdxW + 1 : SLOT_W;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_TIMERS - 1);

    // input unpack
    logic [1:0]           in_op;
    logic [PERIOD_W-1:0]  in_period;
    logic                 in_rep;
    logic [SLOT_W-1:0]    in_slot;
    logic [ELAPSED_W-1:0] in_elapsed;
    logic [IdxW-1:0]      in_slot_idx;
    logic                 in_slot_ok;

    assign in_op       = s_tuser[1:0];
    assign in_period   = s_tdata[31:0];
    assign in_rep      = s_tdata[32];
    assign in_slot     = s_tdata[36:33];
    assign in_elapsed  = s_tdata[52:37];
    assign in_slot_idx = IdxW'(in_slot);
    assign in_slot_ok  = SlotCmpW'(in_slot) < SlotCmpW'(NUM_TIMERS);

    // registers
    ptq_state_t            state_reg, state_next;
    logic [TIME_W-1:0]     now_reg, now_next;
    logic [NUM_TIMERS-1:0] armed_reg, armed_next;
    logic [NUM_TIMERS-1:0] done_reg, done_next;
    logic [IdxW-1:0]       addr_reg, addr_next;
    logic                  issue_reg, issue_next;
    logic [IdxW-1:0]       rd_idx_reg, rd_idx_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic                  best_vld_reg, best_vld_next;
    logic [TIME_W-1:0]     best_dl_reg, best_dl_next;
    logic [IdxW-1:0]       best_idx_reg, best_idx_next;
    logic [PERIOD_W-1:0]   best_per_reg, best_per_next;
    logic                  best_rep_reg, best_rep_next;
    logic [PERIOD_W-1:0]   in_period_reg, in_period_next;
    logic                  in_rep_reg, in_rep_next;
    logic [2:0]            fin_kind_reg, fin_kind_next;
    logic [SLOT_W-1:0]     fin_slot_reg, fin_slot_next;
    logic [PERIOD_W-1:0]   rem_reg, rem_next;
    logic                  empty_reg, empty_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [2:0]            out_kind_reg, out_kind_next;
    logic [SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic [PERIOD_W-1:0]   out_rem_reg, out_rem_next;
    logic                  out_empty_reg, out_empty_next;
    logic                  out_last_reg, out_last_next;

    // memory
    logic [TIME_W-1:0]   dl_mem  [NUM_TIMERS];
    logic [PERIOD_W-1:0] per_mem [NUM_TIMERS];
    logic                rep_mem [NUM_TIMERS];
    logic [TIME_W-1:0]   rd_dl_reg;
    logic [PERIOD_W-1:0] rd_per_reg;
    logic                rd_rep_reg;
    logic                mem_we;
    logic [IdxW-1:0]     mem_waddr;
    logic [TIME_W-1:0]   mem_wdl;
    logic [PERIOD_W-1:0] mem_wper;
    logic                mem_wrep;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            dl_mem[mem_waddr]  <= mem_wdl;
            per_mem[mem_waddr] <= mem_wper;
            rep_mem[mem_waddr] <= mem_wrep;
        end
        rd_dl_reg  <= dl_mem[addr_reg];
        rd_per_reg <= per_mem[addr_reg];
        rd_rep_reg <= rep_mem[addr_reg];
    end

    // shared time adder: tick advance and new deadlines
    logic [PERIOD_W-1:0] add_b;
    logic [TIME_W-1:0]   time_sum;

    always_comb begin
        if (state_reg == ST_IDLE) begin
            add_b = PERIOD_W'(in_elapsed);
        end else if (state_reg == ST_ADD_SCAN) begin
            add_b = in_period_reg;
        end else begin
            add_b = best_per_reg;
        end
    end

    assign time_sum = now_reg + TIME_W'(add_b);

    // compare stage on the registered read data
    logic cand_due, cand_qual, cand_better, scan_last;

    assign cand_due    = rd_dl_reg <= now_reg;
    assign cand_qual   = rd_vld_reg && armed_reg[rd_idx_reg] &&
                         (state_reg == ST_FIN_SCAN || (!done_reg[rd_idx_reg] && cand_due));
    assign cand_better = !best_vld_reg || (rd_dl_reg < best_dl_reg);
    assign scan_last   = rd_vld_reg && (rd_idx_reg == LastIdx);

    // time to earliest deadline, clamped at zero and saturated
    logic [TIME_W:0]     diff;
    logic                diff_pos;
    logic [PERIOD_W-1:0] rem_calc;

    assign diff     = {1'b0, best_dl_reg} - {1'b0, now_reg};
    assign diff_pos = best_vld_reg && !diff[TIME_W] && (diff[TIME_W-1:0] != '0);

    always_comb begin
        if (!diff_pos) begin
            rem_calc = '0;
        end else if (diff[TIME_W-1:PERIOD_W] != '0) begin
            rem_calc = '1;
        end else begin
            rem_calc = diff[PERIOD_W-1:0];
        end
    end

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_op)
                        OP_ADD:    state_next = ST_ADD_SCAN;
                        OP_REMOVE: state_next = ST_FIN_SCAN;
                        OP_TICK:   state_next = ST_TICK_SCAN;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_SCAN: begin
                if (!armed_reg[addr_reg] || addr_reg == LastIdx) begin
                    state_next = ST_FIN_SCAN;
                end
            end
            ST_TICK_SCAN: begin
                if (scan_last) begin
                    state_next = ST_TICK_UPD;
                end
            end
            ST_TICK_UPD: begin
                state_next = best_vld_reg ? ST_EXP_OUT : ST_FIN_SCAN;
            end
            ST_EXP_OUT: begin
                if (out_free) begin
                    state_next = ST_TICK_SCAN;
                end
            end
            ST_FIN_SCAN: begin
                if (scan_last) begin
                    state_next = ST_FIN_CALC;
                end
            end
            ST_FIN_CALC: begin
                state_next = ST_FIN_OUT;
            end
            ST_FIN_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    logic scan_start;
    logic out_load;

    always_comb begin
        now_next       = now_reg;
        armed_next     = armed_reg;
        done_next      = done_reg;
        addr_next      = addr_reg;
        issue_next     = issue_reg;
        rd_idx_next    = rd_idx_reg;
        rd_vld_next    = rd_vld_reg;
        best_vld_next  = best_vld_reg;
        best_dl_next   = best_dl_reg;
        best_idx_next  = best_idx_reg;
        best_per_next  = best_per_reg;
        best_rep_next  = best_rep_reg;
        in_period_next = in_period_reg;
        in_rep_next    = in_rep_reg;
        fin_kind_next  = fin_kind_reg;
        fin_slot_next  = fin_slot_reg;
        rem_next       = rem_reg;
        empty_next     = empty_reg;
        out_kind_next  = out_kind_reg;
        out_slot_next  = out_slot_reg;
        out_rem_next   = out_rem_reg;
        out_empty_next = out_empty_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_waddr      = best_idx_reg;
        mem_wdl        = time_sum;
        mem_wper       = best_per_reg;
        mem_wrep       = best_rep_reg;
        scan_start     = 1'b0;
        out_load       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_op)
                        OP_ADD: begin
                            in_period_next = (in_period == '0) ? PERIOD_W'(1) : in_period;
                            in_rep_next    = in_rep;
                            addr_next      = '0;
                        end
                        OP_REMOVE: begin
                            if (in_slot_ok && armed_reg[in_slot_idx]) begin
                                armed_next[in_slot_idx] = 1'b0;
                                fin_kind_next           = KIND_REMOVED;
                            end else begin
                                fin_kind_next = KIND_NOTFOUND;
                            end
                            fin_slot_next = in_slot;
                            scan_start    = 1'b1;
                        end
                        OP_TICK: begin
                            now_next   = time_sum;
                            done_next  = '0;
                            scan_start = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ADD_SCAN: begin
                if (!armed_reg[addr_reg]) begin
                    mem_we               = 1'b1;
                    mem_waddr            = addr_reg;
                    mem_wper             = in_period_reg;
                    mem_wrep             = in_rep_reg;
                    armed_next[addr_reg] = 1'b1;
                    fin_kind_next        = KIND_ADDED;
                    fin_slot_next        = SLOT_W'(addr_reg);
                    scan_start           = 1'b1;
                end else if (addr_reg == LastIdx) begin
                    fin_kind_next = KIND_FULL;
                    fin_slot_next = '0;
                    scan_start    = 1'b1;
                end else begin
                    addr_next = addr_reg + IdxW'(1);
                end
            end
            ST_TICK_SCAN, ST_FIN_SCAN: begin
                // read address leads the compare through the registered memory read
                if (issue_reg) begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = addr_reg;
                    if (addr_reg == LastIdx) begin
                        issue_next = 1'b0;
                    end else begin
                        addr_next = addr_reg + IdxW'(1);
                    end
                end else begin
                    rd_vld_next = 1'b0;
                end
                if (cand_qual && cand_better) begin
                    best_vld_next = 1'b1;
                    best_dl_next  = rd_dl_reg;
                    best_idx_next = rd_idx_reg;
                    best_per_next = rd_per_reg;
                    best_rep_next = rd_rep_reg;
                end
            end
            ST_TICK_UPD: begin
                if (best_vld_reg) begin
                    done_next[best_idx_reg] = 1'b1;
                    if (best_rep_reg) begin
                        mem_we = 1'b1;
                    end else begin
                        armed_next[best_idx_reg] = 1'b0;
                    end
                end else begin
                    fin_kind_next = KIND_TICKDONE;
                    fin_slot_next = '0;
                    scan_start    = 1'b1;
                end
            end
            ST_EXP_OUT: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_kind_next  = KIND_EXPIRED;
                    out_slot_next  = SLOT_W'(best_idx_reg);
                    out_rem_next   = '0;
                    out_empty_next = 1'b0;
                    out_last_next  = 1'b0;
                    scan_start     = 1'b1;
                end
            end
            ST_FIN_CALC: begin
                rem_next   = rem_calc;
                empty_next = !best_vld_reg;
            end
            ST_FIN_OUT: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_kind_next  = fin_kind_reg;
                    out_slot_next  = fin_slot_reg;
                    out_rem_next   = rem_reg;
                    out_empty_next = empty_reg;
                    out_last_next  = 1'b1;
                end
            end
            default: ;
        endcase

        if (scan_start) begin
            addr_next     = '0;
            issue_next    = 1'b1;
            rd_vld_next   = 1'b0;
            best_vld_next = 1'b0;
        end
    end

    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            now_reg      <= '0;
            armed_reg    <= '0;
            done_reg     <= '0;
            issue_reg    <= 1'b0;
            rd_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            now_reg      <= now_next;
            armed_reg    <= armed_next;
            done_reg     <= done_next;
            issue_reg    <= issue_next;
            rd_vld_reg   <= rd_vld_next;
            best_vld_reg <= best_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        addr_reg      <= addr_next;
        rd_idx_reg    <= rd_idx_next;
        best_dl_reg   <= best_dl_next;
        best_idx_reg  <= best_idx_next;
        best_per_reg  <= best_per_next;
        best_rep_reg  <= best_rep_next;
        in_period_reg <= in_period_next;
        in_rep_reg    <= in_rep_next;
        fin_kind_reg  <= fin_kind_next;
        fin_slot_reg  <= fin_slot_next;
        rem_reg       <= rem_next;
        empty_reg     <= empty_next;
        out_kind_reg  <= out_kind_next;
        out_slot_reg  <= out_slot_next;
        out_rem_reg   <= out_rem_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - SLOT_W - PERIOD_W - 1)'(0), out_empty_reg,
                       out_rem_reg, out_slot_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // the expiry picked by a pass is live, unreported and due
    a_pick_live: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_TICK_UPD && best_vld_reg |->
            armed_reg[best_idx_reg] && !done_reg[best_idx_reg] && best_dl_reg <= now_reg)
        else $error("tick pass picked a slot that is not a live due timer");

    // a final beat hands control back to idle with the beat on the bus
    a_final_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && out_last_next |=> state_reg == ST_IDLE && m_tvalid_reg)
        else $error("final beat loaded without returning to idle");

    // time moves only on an accepted tick
    a_now_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tvalid && s_tready && in_op == OP_TICK) |=> $stable(now_reg))
        else $error("time counter changed outside a tick");

    // no new command while an expiry beat of the current tick is pending
    a_no_accept_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !out_last_reg |-> !s_tready)
        else $error("ready raised before the final beat of a command");

endmodule
